// ===== rtl/bgs_pkg.sv =====
package bgs_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 13;
    localparam int SIZE_W = 14;
    localparam int AREA_W = 27;
    localparam int SUM_W  = 40;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [SUM_W-1:0]  gsum;
        logic [SUM_W-1:0]  esum;
        logic [AREA_W-1:0] area;
    } job_t;

endpackage

// ===== rtl/bgs_if.sv =====
interface bgs_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [bgs_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface bgs_result_if;
    logic                      valid;
    logic                      ready;
    logic [bgs_pkg::SUM_W-1:0] sharpness;
    logic                      zero_mean;

    modport source (output valid, output sharpness, output zero_mean, input ready);
    modport sink (input valid, input sharpness, input zero_mean, output ready);
endinterface

// ===== rtl/bgs_front.sv =====
module bgs_front #(
    parameter int MAX_WIDTH  = bgs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bgs_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [bgs_pkg::CFG_W-1:0]      roi_width,
    input  logic [bgs_pkg::CFG_W-1:0]      roi_height,
    input  logic                           restart,
    bgs_pixel_if.sink                      pixels,
    input  logic [bgs_pkg::QCOUNT_W-1:0]   queue_count,
    output logic                           push,
    output bgs_pkg::job_t                  job
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int PIX_W = bgs_pkg::PIX_W;
    localparam int SQ_W  = 2 * PIX_W;
    localparam int SUM_W = bgs_pkg::SUM_W;
    localparam int SIZE_W = bgs_pkg::SIZE_W;
    localparam int PEND_W = bgs_pkg::QCOUNT_W + 1;

    function automatic logic [SIZE_W-1:0] eff_size(
        input logic [bgs_pkg::CFG_W-1:0] cfg,
        input logic [SIZE_W-1:0]         lim
    );
        logic [SIZE_W-1:0] v;
        logic [SIZE_W-1:0] m;
        begin
            v = {1'b0, cfg[bgs_pkg::CFG_W-1:2], 2'b00};
            m = lim & ~SIZE_W'(3);
            if (v > m)
            begin
                v = m;
            end
            if (v == '0)
            begin
                v = SIZE_W'(4);
            end
            return v;
        end
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(
        input logic [SUM_W-1:0] a,
        input logic [SQ_W-1:0]  b
    );
        logic [SUM_W:0] s;
        begin
            s = {1'b0, a} + (SUM_W + 1)'(b);
            return s[SUM_W] ? bgs_pkg::SUM_MAX : s[SUM_W-1:0];
        end
    endfunction

    logic [PIX_W-1:0] row_mem [MAX_WIDTH];

    logic [SIZE_W-1:0]          w_eff;
    logic [SIZE_W-1:0]          h_eff;
    logic [2*SIZE_W-1:0]        area_full;
    logic [bgs_pkg::AREA_W-1:0] area_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [PIX_W-1:0] prev_reg;
    logic [PIX_W-1:0] above_reg;

    logic             accept;
    logic             last_col;
    logic             last_row;
    logic [1:0]       r;
    logic [1:0]       c;
    logic             vert;
    logic             horz;
    logic [PIX_W-1:0] other;
    logic [PIX_W-1:0] diff;
    logic [PEND_W-1:0] pending;

    logic             s1_valid_reg;
    logic             s1_last_reg;
    logic             s1_pair_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [PIX_W-1:0] s1_diff_reg;

    logic             s2_valid_reg;
    logic             s2_last_reg;
    logic [SQ_W-1:0]  s2_esq_reg;
    logic [SQ_W-1:0]  s2_gsq_reg;

    logic [SUM_W-1:0] gsum_reg;
    logic [SUM_W-1:0] esum_reg;
    logic [SUM_W-1:0] gsum_next;
    logic [SUM_W-1:0] esum_next;

    assign w_eff     = eff_size(roi_width, SIZE_W'(MAX_WIDTH));
    assign h_eff     = eff_size(roi_height, SIZE_W'(MAX_HEIGHT));
    assign area_full = w_eff * h_eff;

    // Reserve a queue slot for every frame end still in the pipeline
    assign pending = PEND_W'(queue_count)
                   + PEND_W'(s1_valid_reg & s1_last_reg)
                   + PEND_W'(s2_valid_reg & s2_last_reg);
    assign pixels.ready = (pending < PEND_W'(bgs_pkg::QUEUE_DEPTH));
    assign accept = pixels.valid & pixels.ready;

    always_comb
    begin
        last_col = (SIZE_W'(col_reg) == w_eff - SIZE_W'(1));
        last_row = (SIZE_W'(row_reg) == h_eff - SIZE_W'(1));
        r = row_reg[1:0];
        c = col_reg[1:0];
        vert = (r == 2'd1 && !c[1]) || (r == 2'd3 && c[1]);
        horz = (c == 2'd3 && !r[1]) || (c == 2'd1 && r[1]);
        other = vert ? above_reg : prev_reg;
        diff = (other > pixels.pixel) ? (other - pixels.pixel) : (pixels.pixel - other);

        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // Read ahead at the column of the next pixel; a write never hits it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_mem[col_reg] <= pixels.pixel;
        end
        above_reg <= row_mem[col_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (restart)
            begin
                prev_reg <= '0;
            end
            else if (accept)
            begin
                prev_reg <= pixels.pixel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        area_reg    <= area_full[bgs_pkg::AREA_W-1:0];
        s1_pix_reg  <= pixels.pixel;
        s1_diff_reg <= diff;
        s1_pair_reg <= vert | horz;
        s1_last_reg <= last_col & last_row;
        s2_esq_reg  <= s1_pix_reg * s1_pix_reg;
        s2_gsq_reg  <= s1_pair_reg ? s1_diff_reg * s1_diff_reg : '0;
        s2_last_reg <= s1_last_reg;
    end

    assign gsum_next = sat_add(gsum_reg, s2_gsq_reg);
    assign esum_next = sat_add(esum_reg, s2_esq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            gsum_reg     <= '0;
            esum_reg     <= '0;
        end
        else if (restart)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            gsum_reg     <= '0;
            esum_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                gsum_reg <= s2_last_reg ? '0 : gsum_next;
                esum_reg <= s2_last_reg ? '0 : esum_next;
            end
        end
    end

    assign push      = s2_valid_reg & s2_last_reg;
    assign job.gsum  = gsum_next;
    assign job.esum  = esum_next;
    assign job.area  = area_reg;

endmodule

// ===== rtl/bgs_queue.sv =====
module bgs_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  bgs_pkg::job_t                push_data,
    input  logic                         pop,
    output logic                         head_valid,
    output bgs_pkg::job_t                head,
    output logic [bgs_pkg::QCOUNT_W-1:0] count
);

    localparam int DEPTH = bgs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = bgs_pkg::QPTR_W;
    localparam int CNT_W = bgs_pkg::QCOUNT_W;

    bgs_pkg::job_t    slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign head_valid = (count_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop & head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/bgs_div.sv =====
module bgs_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bgs_pkg::SUM_W-1:0] dividend,
    input  logic [bgs_pkg::SUM_W-1:0] divisor,
    output logic                      done,
    output logic [bgs_pkg::SUM_W-1:0] quotient
);

    localparam int W     = bgs_pkg::SUM_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       shifted;
    logic [W+1:0]     trial;

    assign shifted  = {rem_reg, quo_reg[W-1]};
    assign trial    = {1'b0, shifted} - {2'b00, dsr_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    // One quotient bit per cycle, restoring
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[W+1])
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== rtl/bgs_back.sv =====
module bgs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  bgs_pkg::job_t job,
    output logic          pop,
    bgs_result_if.source  results
);

    localparam int W = bgs_pkg::SUM_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MEAN = 2'd1;
    localparam logic [1:0] ST_QUOT = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]   state_reg;
    logic [1:0]   state_next;
    logic [W-1:0] gsum_reg;
    logic [W-1:0] res_reg;
    logic         zm_reg;
    logic         out_valid_reg;
    logic [W-1:0] out_sharp_reg;
    logic         out_zm_reg;

    logic         div_start;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic         div_done;
    logic [W-1:0] div_q;
    logic         out_free;
    logic         load_out;

    bgs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        dividend   = gsum_reg;
        divisor    = div_q;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                // mean square = energy / area
                if (job_valid)
                begin
                    pop        = 1'b1;
                    div_start  = 1'b1;
                    dividend   = job.esum;
                    divisor    = W'(job.area);
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (div_done)
                begin
                    if (div_q == '0)
                    begin
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_QUOT;
                    end
                end
            end
            ST_QUOT:
            begin
                if (div_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid)
        begin
            gsum_reg <= job.gsum;
        end
        if (state_reg == ST_MEAN && div_done && div_q == '0)
        begin
            res_reg <= bgs_pkg::SUM_MAX;
            zm_reg  <= 1'b1;
        end
        else if (state_reg == ST_QUOT && div_done)
        begin
            res_reg <= div_q;
            zm_reg  <= 1'b0;
        end
        if (load_out)
        begin
            out_sharp_reg <= res_reg;
            out_zm_reg    <= zm_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.sharpness = out_sharp_reg;
    assign results.zero_mean = out_zm_reg;

endmodule

// ===== rtl/block_gradient_sharpness_top.sv =====
// Block gradient sharpness: focus measure over a region of interest.
// pixels: one 8-bit pixel per beat in raster order; a new beat can be taken
// every clock unless stalled. The region is width x height (set over the APB
// port, low two bits ignored, clamped to 4..MAX). results: one beat per
// region carrying sharpness = gradient_sum / (energy_sum / (width*height))
// and zero_mean. The front accumulates one pixel per clock unless stalled.
// With the back idle, the time from the last pixel of a region to the result
// is set by the passes of the bit-serial divider in the back: one pass when
// the mean square is zero, two otherwise. The back takes one region at a time.
// A two-entry queue holds finished region sums, so the next region streams in
// while the divider works. The pixel input stalls, at any pixel, while two
// finished regions wait for the back, either queued or still in the front
// pipeline. A stalled receiver holds the result in the output register;
// the back then waits, the queue fills, and the input stalls after that.
// Reset sets width and height to 64 and clears counters and sums. Any
// register write restarts the current region; write only when idle.
module block_gradient_sharpness_top #(
    parameter int MAX_WIDTH  = bgs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bgs_pkg::MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bgs_pixel_if.sink   pixels,
    bgs_result_if.source results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CFG_W = bgs_pkg::CFG_W;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(64);

    logic [CFG_W-1:0]              roi_width_reg;
    logic [CFG_W-1:0]              roi_height_reg;
    logic                          wr_en;
    logic                          push;
    bgs_pkg::job_t                 push_job;
    logic                          pop;
    logic                          head_valid;
    bgs_pkg::job_t                 head;
    logic [bgs_pkg::QCOUNT_W-1:0]  queue_count;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roi_width_reg  <= SIZE_RESET;
            roi_height_reg <= SIZE_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_WIDTH:  roi_width_reg  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: roi_height_reg <= pwdata[CFG_W-1:0];
                default:    roi_width_reg  <= roi_width_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(roi_height_reg) : 32'(roi_width_reg);

    bgs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .roi_width   (roi_width_reg),
        .roi_height  (roi_height_reg),
        .restart     (wr_en),
        .pixels      (pixels),
        .queue_count (queue_count),
        .push        (push),
        .job         (push_job)
    );

    bgs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (queue_count)
    );

    bgs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head),
        .pop       (pop),
        .results   (results)
    );

endmodule
